[hw/rtl/tmg_pkg.sv]
// tmg_pkg: shared constants, field layouts and types of the tone map block
// used by every file under hw/rtl; depends on nothing
package tmg_pkg;

  localparam int CHANNEL_FRAC_BITS = 12;
  localparam int GAMMA_INDEX_BITS  = 10;
  localparam int COORD_BITS        = 12;
  localparam int CHAN_BITS         = 16;
  localparam int PIX_BITS          = 8;
  localparam int VRES_BITS         = 13;
  localparam int NUM_CH            = 3;

  localparam int TABLE_DEPTH = 1 << GAMMA_INDEX_BITS;
  localparam int QUO_BITS    = CHANNEL_FRAC_BITS + 1;
  localparam int DIV_STAGES  = QUO_BITS;
  localparam int DVS_BITS    = CHAN_BITS + 1;
  localparam int REM_BITS    = CHAN_BITS + 2;
  localparam int PROD_BITS   = QUO_BITS + GAMMA_INDEX_BITS + 1;
  localparam int LIN_BITS    = QUO_BITS + PIX_BITS;

  localparam logic [DVS_BITS-1:0]         CHAN_ONE  = DVS_BITS'(1) << CHANNEL_FRAC_BITS;
  localparam logic [DVS_BITS-1:0]         CHAN_HALF = CHAN_ONE >> 1;
  localparam logic [GAMMA_INDEX_BITS-1:0] TABLE_MAX = '1;
  localparam logic [PIX_BITS-1:0]         PIX_MAX   = '1;

  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = VRES_BITS;
  localparam logic [VRES_BITS-1:0] VRES_RESET = VRES_BITS'(480);

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_CLAMP_MODE   = 2'd0,
    CFG_GAMMA_ENABLE = 2'd1,
    CFG_VERTICAL_RES = 2'd2
  } cfg_idx_t;

  localparam logic REQ_PIXEL       = 1'b0;
  localparam logic REQ_TABLE_WRITE = 1'b1;

  // input tdata layout
  localparam int IN_ROW_LSB   = 0;
  localparam int IN_COL_LSB   = IN_ROW_LSB + COORD_BITS;
  localparam int IN_RED_LSB   = IN_COL_LSB + COORD_BITS;
  localparam int IN_GREEN_LSB = IN_RED_LSB + CHAN_BITS;
  localparam int IN_BLUE_LSB  = IN_GREEN_LSB + CHAN_BITS;
  localparam int IN_TIDX_LSB  = IN_BLUE_LSB + CHAN_BITS;
  localparam int IN_TVAL_LSB  = IN_TIDX_LSB + GAMMA_INDEX_BITS;
  localparam int IN_FIELD_BITS = IN_TVAL_LSB + PIX_BITS;
  localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;

  // output tdata layout
  localparam int OUT_X_LSB     = 0;
  localparam int OUT_Y_LSB     = OUT_X_LSB + COORD_BITS;
  localparam int OUT_RED_LSB   = OUT_Y_LSB + COORD_BITS;
  localparam int OUT_GREEN_LSB = OUT_RED_LSB + PIX_BITS;
  localparam int OUT_BLUE_LSB  = OUT_GREEN_LSB + PIX_BITS;
  localparam int OUT_FIELD_BITS = OUT_BLUE_LSB + PIX_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef logic [CHAN_BITS-1:0] chan_t;
  typedef chan_t [NUM_CH-1:0]   chan_vec_t;
  typedef logic [QUO_BITS-1:0]  norm_t;

  typedef struct packed {
    logic                        wr;
    logic [COORD_BITS-1:0]       row;
    logic [COORD_BITS-1:0]       col;
    chan_vec_t                   ch;
    logic [GAMMA_INDEX_BITS-1:0] tidx;
    logic [PIX_BITS-1:0]         tval;
  } item_t;

  // per-transaction sideband that rides along the channel datapath
  typedef struct packed {
    logic                        vld;
    logic                        wr;
    logic [COORD_BITS-1:0]       x;
    logic [COORD_BITS-1:0]       y;
    logic [GAMMA_INDEX_BITS-1:0] tidx;
    logic [PIX_BITS-1:0]         tval;
  } side_t;

endpackage

[hw/rtl/tmg_prep.sv]
// tmg_prep: input register, channel max, clamp, divisor select and row flip
// depends on tmg_pkg
module tmg_prep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  tmg_pkg::item_t                item,
  input  logic                          clamp_mode,
  input  logic [tmg_pkg::VRES_BITS-1:0] vres,
  output tmg_pkg::side_t                side,
  output tmg_pkg::chan_vec_t            ch,
  output logic [tmg_pkg::DVS_BITS-1:0]  dvs
);

  logic                          a_vld_r;
  tmg_pkg::item_t                a_item_r;
  tmg_pkg::side_t                b_side_r;
  tmg_pkg::chan_vec_t            b_ch_r;
  logic [tmg_pkg::DVS_BITS-1:0]  b_dvs_r;

  tmg_pkg::side_t                b_side_nxt;
  tmg_pkg::chan_vec_t            b_ch_nxt;
  logic [tmg_pkg::DVS_BITS-1:0]  b_dvs_nxt;
  tmg_pkg::chan_t                mx;

  always_comb begin
    mx = a_item_r.ch[0];
    if (a_item_r.ch[1] > mx) begin
      mx = a_item_r.ch[1];
    end
    if (a_item_r.ch[2] > mx) begin
      mx = a_item_r.ch[2];
    end
    for (int c = 0; c < tmg_pkg::NUM_CH; c++) begin
      b_ch_nxt[c] = a_item_r.ch[c];
      if (clamp_mode && (tmg_pkg::DVS_BITS'(a_item_r.ch[c]) > tmg_pkg::CHAN_ONE)) begin
        b_ch_nxt[c] = tmg_pkg::CHAN_BITS'(tmg_pkg::CHAN_ONE);
      end
    end
    // dividing by one leaves in-range values untouched
    if (!clamp_mode && (tmg_pkg::DVS_BITS'(mx) > tmg_pkg::CHAN_ONE)) begin
      b_dvs_nxt = tmg_pkg::DVS_BITS'(mx);
    end else begin
      b_dvs_nxt = tmg_pkg::CHAN_ONE;
    end
    b_side_nxt.vld  = a_vld_r;
    b_side_nxt.wr   = a_item_r.wr;
    b_side_nxt.x    = a_item_r.col;
    b_side_nxt.y    = tmg_pkg::COORD_BITS'(vres) - tmg_pkg::COORD_BITS'(1) - a_item_r.row;
    b_side_nxt.tidx = a_item_r.tidx;
    b_side_nxt.tval = a_item_r.tval;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r      <= 1'b0;
      b_side_r.vld <= 1'b0;
    end else if (en) begin
      a_vld_r  <= in_vld;
      a_item_r <= item;
      b_side_r <= b_side_nxt;
      b_ch_r   <= b_ch_nxt;
      b_dvs_r  <= b_dvs_nxt;
    end
  end

  assign side = b_side_r;
  assign ch   = b_ch_r;
  assign dvs  = b_dvs_r;

endmodule

[hw/rtl/tmg_div.sv]
// tmg_div: pipelined restoring divider, one quotient bit per stage, gives
// floor(ch * one / dvs) for ch <= dvs; depends on tmg_pkg
module tmg_div (
  input  logic                         clk,
  input  logic                         en,
  input  tmg_pkg::chan_t               ch,
  input  logic [tmg_pkg::DVS_BITS-1:0] dvs,
  output tmg_pkg::norm_t               q
);

  logic [tmg_pkg::REM_BITS-1:0] rem_r [tmg_pkg::DIV_STAGES];
  logic [tmg_pkg::DVS_BITS-1:0] dvs_r [tmg_pkg::DIV_STAGES];
  tmg_pkg::norm_t               q_r   [tmg_pkg::DIV_STAGES];

  for (genvar s = 0; s < tmg_pkg::DIV_STAGES; s++) begin : g_stage
    logic [tmg_pkg::REM_BITS-1:0] trial;
    logic [tmg_pkg::DVS_BITS-1:0] d_in;
    tmg_pkg::norm_t               q_in;
    logic                         qbit;
    logic [tmg_pkg::REM_BITS-1:0] rem_nxt;
    tmg_pkg::norm_t               q_nxt;

    if (s == 0) begin : g_first
      assign trial = tmg_pkg::REM_BITS'(ch);
      assign d_in  = dvs;
      assign q_in  = '0;
    end else begin : g_next
      assign trial = {rem_r[s-1][tmg_pkg::REM_BITS-2:0], 1'b0};
      assign d_in  = dvs_r[s-1];
      assign q_in  = q_r[s-1];
    end

    always_comb begin
      qbit    = (trial >= tmg_pkg::REM_BITS'(d_in));
      rem_nxt = qbit ? (trial - tmg_pkg::REM_BITS'(d_in)) : trial;
      q_nxt   = {q_in[tmg_pkg::QUO_BITS-2:0], qbit};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        dvs_r[s] <= d_in;
        q_r[s]   <= q_nxt;
      end
    end
  end

  assign q = q_r[tmg_pkg::DIV_STAGES-1];

endmodule

[hw/rtl/tmg_gamma_ram.sv]
// tmg_gamma_ram: one copy of the gamma table, single port, registered read
// depends on tmg_pkg
module tmg_gamma_ram (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic                                 we,
  input  logic [tmg_pkg::GAMMA_INDEX_BITS-1:0] addr,
  input  logic [tmg_pkg::PIX_BITS-1:0]         wdata,
  output logic [tmg_pkg::PIX_BITS-1:0]         rdata
);

  logic [tmg_pkg::PIX_BITS-1:0] mem [tmg_pkg::TABLE_DEPTH];
  logic [tmg_pkg::PIX_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/pixel_tone_map_gamma.sv]
// pixel_tone_map_gamma: top level of the hdr tone map and gamma block
// depends on tmg_pkg, tmg_prep, tmg_div and tmg_gamma_ram
//
// One transaction enters per clock while in_tready is high. A pixel
// result passes through two input and prep stages, one divider stage
// per quotient bit of the normalize division, then index/scale, gamma
// read and output register. The whole pipeline advances whenever the
// output register is empty or taken, so in_tready drops only while a
// result waits with out_tready low, and the whole pipeline, bubbles
// included, holds for that time. A tuser of one marks a gamma table
// write, which yields no result; it updates three copies of the table
// (one per channel) in stream order, so later pixels see it. The table
// has no reset and no clearing pass: a pixel that reads an entry never
// written gives undefined color. Write configuration only while the
// pipeline is empty.
module pixel_tone_map_gamma (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // row, col, red_in, green_in, blue_in, table_index, table_value, zero pad
  input  logic [tmg_pkg::IN_DATA_BITS-1:0]   in_tdata,
  // req_type
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // x_out, y_out, red_out, green_out, blue_out
  output logic [tmg_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tmg_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [tmg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  logic                          clamp_mode_r;
  logic                          gamma_enable_r;
  logic [tmg_pkg::VRES_BITS-1:0] vres_r;

  logic                          en;
  tmg_pkg::item_t                item;
  tmg_pkg::side_t                prep_side;
  tmg_pkg::chan_vec_t            prep_ch;
  logic [tmg_pkg::DVS_BITS-1:0]  prep_dvs;
  tmg_pkg::norm_t                norm [tmg_pkg::NUM_CH];

  tmg_pkg::side_t                side_r [tmg_pkg::DIV_STAGES];
  tmg_pkg::side_t                m_side_r;
  tmg_pkg::side_t                g_side_r;
  logic [tmg_pkg::GAMMA_INDEX_BITS-1:0] m_idx_r [tmg_pkg::NUM_CH];
  logic [tmg_pkg::PIX_BITS-1:0]  m_lin_r [tmg_pkg::NUM_CH];
  logic [tmg_pkg::PIX_BITS-1:0]  g_lin_r [tmg_pkg::NUM_CH];
  logic [tmg_pkg::PIX_BITS-1:0]  ram_q   [tmg_pkg::NUM_CH];

  logic                              out_tvalid_r;
  logic [tmg_pkg::OUT_DATA_BITS-1:0] out_data_r;
  logic [tmg_pkg::OUT_DATA_BITS-1:0] out_data_nxt;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_mode_r   <= 1'b0;
      gamma_enable_r <= 1'b0;
      vres_r         <= tmg_pkg::VRES_RESET;
    end else if (cfg_valid) begin
      case (cfg_addr)
        tmg_pkg::CFG_CLAMP_MODE:   clamp_mode_r   <= cfg_data[0];
        tmg_pkg::CFG_GAMMA_ENABLE: gamma_enable_r <= cfg_data[0];
        tmg_pkg::CFG_VERTICAL_RES: vres_r         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  always_comb begin
    item.wr   = (in_tuser == tmg_pkg::REQ_TABLE_WRITE);
    item.row  = in_tdata[tmg_pkg::IN_ROW_LSB +: tmg_pkg::COORD_BITS];
    item.col  = in_tdata[tmg_pkg::IN_COL_LSB +: tmg_pkg::COORD_BITS];
    item.ch[0] = in_tdata[tmg_pkg::IN_RED_LSB +: tmg_pkg::CHAN_BITS];
    item.ch[1] = in_tdata[tmg_pkg::IN_GREEN_LSB +: tmg_pkg::CHAN_BITS];
    item.ch[2] = in_tdata[tmg_pkg::IN_BLUE_LSB +: tmg_pkg::CHAN_BITS];
    item.tidx = in_tdata[tmg_pkg::IN_TIDX_LSB +: tmg_pkg::GAMMA_INDEX_BITS];
    item.tval = in_tdata[tmg_pkg::IN_TVAL_LSB +: tmg_pkg::PIX_BITS];
  end

  tmg_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (in_tvalid),
    .item       (item),
    .clamp_mode (clamp_mode_r),
    .vres       (vres_r),
    .side       (prep_side),
    .ch         (prep_ch),
    .dvs        (prep_dvs)
  );

  // sideband line matching the divider depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < tmg_pkg::DIV_STAGES; s++) begin
        side_r[s].vld <= 1'b0;
      end
      m_side_r.vld <= 1'b0;
      g_side_r.vld <= 1'b0;
    end else if (en) begin
      side_r[0] <= prep_side;
      for (int s = 1; s < tmg_pkg::DIV_STAGES; s++) begin
        side_r[s] <= side_r[s-1];
      end
      m_side_r <= side_r[tmg_pkg::DIV_STAGES-1];
      g_side_r <= m_side_r;
    end
  end

  for (genvar c = 0; c < tmg_pkg::NUM_CH; c++) begin : g_chan
    logic [tmg_pkg::PROD_BITS-1:0]        prod;
    logic [tmg_pkg::PROD_BITS-1:0]        idx_full;
    logic [tmg_pkg::GAMMA_INDEX_BITS-1:0] idx_nxt;
    logic [tmg_pkg::LIN_BITS-1:0]         lin_prod;
    logic [tmg_pkg::LIN_BITS-1:0]         lin_full;
    logic [tmg_pkg::PIX_BITS-1:0]         lin_nxt;

    tmg_div u_div (
      .clk (clk),
      .en  (en),
      .ch  (prep_ch[c]),
      .dvs (prep_dvs),
      .q   (norm[c])
    );

    always_comb begin
      prod = tmg_pkg::PROD_BITS'(norm[c]) * tmg_pkg::PROD_BITS'(tmg_pkg::TABLE_MAX)
           + tmg_pkg::PROD_BITS'(tmg_pkg::CHAN_HALF);
      idx_full = prod >> tmg_pkg::CHANNEL_FRAC_BITS;
      if (idx_full > tmg_pkg::PROD_BITS'(tmg_pkg::TABLE_MAX)) begin
        idx_nxt = tmg_pkg::TABLE_MAX;
      end else begin
        idx_nxt = idx_full[tmg_pkg::GAMMA_INDEX_BITS-1:0];
      end
      lin_prod = tmg_pkg::LIN_BITS'(norm[c]) * tmg_pkg::LIN_BITS'(tmg_pkg::PIX_MAX);
      lin_full = lin_prod >> tmg_pkg::CHANNEL_FRAC_BITS;
      if (lin_full > tmg_pkg::LIN_BITS'(tmg_pkg::PIX_MAX)) begin
        lin_nxt = tmg_pkg::PIX_MAX;
      end else begin
        lin_nxt = lin_full[tmg_pkg::PIX_BITS-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_idx_r[c] <= idx_nxt;
        m_lin_r[c] <= lin_nxt;
        g_lin_r[c] <= m_lin_r[c];
      end
    end

    // table writes land here, in stream order with the pixel reads
    tmg_gamma_ram u_ram (
      .clk   (clk),
      .en    (en),
      .we    (m_side_r.vld && m_side_r.wr),
      .addr  (m_side_r.wr ? m_side_r.tidx : m_idx_r[c]),
      .wdata (m_side_r.tval),
      .rdata (ram_q[c])
    );
  end

  // output register
  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[tmg_pkg::OUT_X_LSB +: tmg_pkg::COORD_BITS] = g_side_r.x;
    out_data_nxt[tmg_pkg::OUT_Y_LSB +: tmg_pkg::COORD_BITS] = g_side_r.y;
    out_data_nxt[tmg_pkg::OUT_RED_LSB +: tmg_pkg::PIX_BITS] =
      gamma_enable_r ? ram_q[0] : g_lin_r[0];
    out_data_nxt[tmg_pkg::OUT_GREEN_LSB +: tmg_pkg::PIX_BITS] =
      gamma_enable_r ? ram_q[1] : g_lin_r[1];
    out_data_nxt[tmg_pkg::OUT_BLUE_LSB +: tmg_pkg::PIX_BITS] =
      gamma_enable_r ? ram_q[2] : g_lin_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= g_side_r.vld && !g_side_r.wr;
      out_data_r   <= out_data_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // divisor is at least one and covers every channel
  a_dvs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    prep_side.vld |-> (prep_dvs >= tmg_pkg::CHAN_ONE)
      && (tmg_pkg::DVS_BITS'(prep_ch[0]) <= prep_dvs)
      && (tmg_pkg::DVS_BITS'(prep_ch[1]) <= prep_dvs)
      && (tmg_pkg::DVS_BITS'(prep_ch[2]) <= prep_dvs))
    else $error("divisor below a channel or below one");

  // normalized channels never exceed one
  a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    side_r[tmg_pkg::DIV_STAGES-1].vld |->
      (tmg_pkg::DVS_BITS'(norm[0]) <= tmg_pkg::CHAN_ONE)
      && (tmg_pkg::DVS_BITS'(norm[1]) <= tmg_pkg::CHAN_ONE)
      && (tmg_pkg::DVS_BITS'(norm[2]) <= tmg_pkg::CHAN_ONE))
    else $error("normalized channel above one");

  // a result only appears from a pixel transaction at the gamma stage
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(en && g_side_r.vld && !g_side_r.wr))
    else $error("result without a pixel transaction");

endmodule

[tb/pixel_tone_map_gamma_tb.sv]
`timescale 1ns / 100ps
// pixel_tone_map_gamma_tb: self-checking bench for the hdr tone map and gamma block
// drives pixels, gamma table loads and register writes with random gaps and stalls,
// predicts each result in-bench and compares it field by field; needs tmg_pkg and the rtl
module pixel_tone_map_gamma_tb;
  import tmg_pkg::*;

  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 11;
  localparam int MAX_GAP       = 18;
  localparam int SETTLE_CYCLES = 30;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 115;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_UNUSED = 2'd3;

  typedef logic [DVS_BITS-1:0] level_t;
  typedef logic [NUM_CH-1:0][DVS_BITS-1:0] level_vec_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [PIX_BITS-1:0]   red;
    logic [PIX_BITS-1:0]   green;
    logic [PIX_BITS-1:0]   blue;
  } pix_out_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [IN_DATA_BITS-1:0]   in_tdata;
  logic                      in_tuser;
  logic                      out_tvalid;
  logic                      out_tready;
  logic [OUT_DATA_BITS-1:0]  out_tdata;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_ADDR_BITS-1:0]  cfg_addr;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  logic                  clamp_on;
  logic                  gamma_on;
  logic [VRES_BITS-1:0]  vres_q;
  logic [PIX_BITS-1:0]   lut_q [TABLE_DEPTH];
  bit                    lut_written [TABLE_DEPTH];
  pix_out_t              pixel_due_q [$];
  pix_out_t              due_pix;
  int                    errors = 0;
  int                    tx_gap_lim = 3;
  int                    rx_gap_lim = 3;
  int                    rx_wait = 0;
  bit                    rx_took = 1'b0;
  int                    idle_cycles = 0;

  pixel_tone_map_gamma dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic chan_vec_t rgb(input chan_t r, input chan_t g, input chan_t b);
    chan_vec_t v;
    v[0] = r;
    v[1] = g;
    v[2] = b;
    return v;
  endfunction

  // clamp or normalize by the brightest channel
  function automatic level_vec_t tone_levels(input chan_vec_t ch);
    level_vec_t  lv;
    level_t      peak;
    logic [31:0] scaled;
    peak = '0;
    for (int k = 0; k < NUM_CH; k++) begin
      lv[k] = level_t'(ch[k]);
      if (lv[k] > peak) peak = lv[k];
    end
    for (int k = 0; k < NUM_CH; k++) begin
      if (clamp_on) begin
        if (lv[k] > CHAN_ONE) lv[k] = CHAN_ONE;
      end else if (peak > CHAN_ONE) begin
        scaled = (32'(lv[k]) << CHANNEL_FRAC_BITS) / 32'(peak);
        lv[k]  = level_t'(scaled);
      end
    end
    return lv;
  endfunction

  function automatic logic [GAMMA_INDEX_BITS-1:0] lut_slot(input level_t n);
    logic [31:0] idx;
    idx = (32'(n) * 32'(TABLE_MAX) + 32'(CHAN_HALF)) >> CHANNEL_FRAC_BITS;
    if (idx > 32'(TABLE_MAX)) idx = 32'(TABLE_MAX);
    return GAMMA_INDEX_BITS'(idx);
  endfunction

  function automatic logic [PIX_BITS-1:0] display_level(input level_t n);
    logic [31:0] lin;
    if (gamma_on) return lut_q[lut_slot(n)];
    lin = (32'(n) * 32'(PIX_MAX)) >> CHANNEL_FRAC_BITS;
    return (lin > 32'(PIX_MAX)) ? PIX_MAX : PIX_BITS'(lin);
  endfunction

  function automatic pix_out_t predict_pixel(input logic [COORD_BITS-1:0] row,
                                             input logic [COORD_BITS-1:0] col,
                                             input chan_vec_t ch);
    pix_out_t   p;
    level_vec_t lv;
    lv      = tone_levels(ch);
    p.x     = col;
    p.y     = COORD_BITS'(32'(vres_q) - 32'd1 - 32'(row));
    p.red   = display_level(lv[0]);
    p.green = display_level(lv[1]);
    p.blue  = display_level(lv[2]);
    return p;
  endfunction

  function automatic logic [IN_DATA_BITS-1:0] pack_item(
      input logic [COORD_BITS-1:0] row, input logic [COORD_BITS-1:0] col,
      input chan_vec_t ch, input logic [GAMMA_INDEX_BITS-1:0] slot,
      input logic [PIX_BITS-1:0] val);
    logic [IN_DATA_BITS-1:0] d;
    d = '0;
    d[IN_ROW_LSB +: COORD_BITS]         = row;
    d[IN_COL_LSB +: COORD_BITS]         = col;
    d[IN_RED_LSB +: CHAN_BITS]          = ch[0];
    d[IN_GREEN_LSB +: CHAN_BITS]        = ch[1];
    d[IN_BLUE_LSB +: CHAN_BITS]         = ch[2];
    d[IN_TIDX_LSB +: GAMMA_INDEX_BITS]  = slot;
    d[IN_TVAL_LSB +: PIX_BITS]          = val;
    return d;
  endfunction

  function automatic chan_t pick_radiance();
    case ($urandom_range(0, 5))
      0, 1:    return chan_t'($urandom_range(0, CHAN_ONE));
      2:       return chan_t'($urandom_range(CHAN_ONE - 6, CHAN_ONE + 6));
      3:       return chan_t'($urandom);
      4:       return chan_t'($urandom_range(CHAN_ONE + 1, 4 * CHAN_ONE));
      default: begin
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return chan_t'(CHAN_ONE);
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic chan_vec_t any_chan_vec();
    return rgb(chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
  endfunction

  task automatic push_item(input logic kind, input logic [IN_DATA_BITS-1:0] data);
    int        gap;
    chan_vec_t ch;
    gap = $urandom_range(0, tx_gap_lim);
    repeat (gap) @(negedge clk) in_tvalid <= 1'b0;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    if (kind == REQ_TABLE_WRITE) begin
      lut_q[data[IN_TIDX_LSB +: GAMMA_INDEX_BITS]]       = data[IN_TVAL_LSB +: PIX_BITS];
      lut_written[data[IN_TIDX_LSB +: GAMMA_INDEX_BITS]] = 1'b1;
    end else begin
      ch = rgb(data[IN_RED_LSB +: CHAN_BITS], data[IN_GREEN_LSB +: CHAN_BITS],
               data[IN_BLUE_LSB +: CHAN_BITS]);
      pixel_due_q.insert(pixel_due_q.size(),
                         predict_pixel(data[IN_ROW_LSB +: COORD_BITS],
                                       data[IN_COL_LSB +: COORD_BITS], ch));
    end
  endtask

  task automatic load_lut(input logic [GAMMA_INDEX_BITS-1:0] slot, input logic [PIX_BITS-1:0] val);
    push_item(REQ_TABLE_WRITE, pack_item(COORD_BITS'($urandom), COORD_BITS'($urandom),
                                         any_chan_vec(), slot, val));
  endtask

  // with gamma on, entries a pixel will read get loaded first
  task automatic send_pixel(input logic [COORD_BITS-1:0] row, input logic [COORD_BITS-1:0] col,
                            input chan_vec_t ch);
    level_vec_t                  lv;
    logic [GAMMA_INDEX_BITS-1:0] slot;
    if (gamma_on) begin
      lv = tone_levels(ch);
      for (int k = 0; k < NUM_CH; k++) begin
        slot = lut_slot(lv[k]);
        if (!lut_written[slot]) load_lut(slot, PIX_BITS'($urandom));
      end
    end
    push_item(REQ_PIXEL, pack_item(row, col, ch, GAMMA_INDEX_BITS'($urandom),
                                   PIX_BITS'($urandom)));
  endtask

  task automatic wait_idle();
    @(negedge clk) in_tvalid <= 1'b0;
    while (pixel_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CLAMP_MODE:   clamp_on = val[0];
      CFG_GAMMA_ENABLE: gamma_on = val[0];
      CFG_VERTICAL_RES: vres_q   = val;
      default: ;
    endcase
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic set_mode(input logic clamp, input logic gamma,
                          input logic [CFG_DATA_BITS-1:0] vres);
    logic [CFG_DATA_BITS-1:0] word;
    wait_idle();
    word    = CFG_DATA_BITS'($urandom);
    word[0] = clamp;
    write_reg(CFG_CLAMP_MODE, word);
    word    = CFG_DATA_BITS'($urandom);
    word[0] = gamma;
    write_reg(CFG_GAMMA_ENABLE, word);
    write_reg(CFG_VERTICAL_RES, vres);
  endtask

  task automatic test_reset_defaults();
    send_pixel(12'd0, 12'd0, rgb(16'd0, 16'd0, 16'd0));
    send_pixel(12'd4095, 12'd4095, rgb(16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(12'd479, 12'd1, rgb(16'd4096, 16'd4096, 16'd4096));
    send_pixel(12'd480, 12'd2, rgb(16'd4097, 16'd0, 16'd2048));
    send_pixel(12'd5, 12'd7, rgb(16'hFFFF, 16'd1, 16'd4096));
  endtask

  task automatic test_clamp_linear();
    set_mode(1'b1, 1'b0, 13'd480);
    send_pixel(12'd3, 12'd4, rgb(16'd4097, 16'd4096, 16'hFFFF));
    send_pixel(12'd4095, 12'd0, rgb(16'd4095, 16'd0, 16'd1));
    send_pixel(12'd10, 12'd20, rgb(16'hFFFF, 16'hFFFF, 16'hFFFF));
  endtask

  task automatic test_gamma_lookup();
    set_mode(1'b0, 1'b1, 13'd1080);
    load_lut('0, 8'h00);
    load_lut(TABLE_MAX, 8'hFF);
    load_lut(10'd512, 8'hA5);
    load_lut(10'd1, 8'h5A);
    send_pixel(12'd0, 12'd9, rgb(16'd0, 16'd4096, 16'd2048));
    send_pixel(12'd1079, 12'd9, rgb(16'hFFFF, 16'd0, 16'h8000));
    set_mode(1'b1, 1'b1, 13'd1080);
    send_pixel(12'd2000, 12'd3, rgb(16'hFFFF, 16'd4097, 16'd2049));
  endtask

  task automatic test_flip_extremes();
    set_mode(1'b0, 1'b0, 13'd1);
    send_pixel(12'd0, 12'd100, rgb(16'd1, 16'd2, 16'd3));
    send_pixel(12'd1, 12'd100, rgb(16'd1, 16'd2, 16'd3));
    set_mode(1'b0, 1'b0, 13'd4096);
    send_pixel(12'd0, 12'd200, rgb(16'd9, 16'd8, 16'd7));
    send_pixel(12'd4095, 12'd200, rgb(16'd9, 16'd8, 16'd7));
    set_mode(1'b0, 1'b0, 13'd0);
    send_pixel(12'd0, 12'd300, rgb(16'd4096, 16'd0, 16'd4096));
    set_mode(1'b0, 1'b0, 13'h1FFF);
    send_pixel(12'd4095, 12'd300, rgb(16'd4096, 16'd0, 16'd4096));
    wait_idle();
    write_reg(CFG_UNUSED, '1);
    send_pixel(12'd17, 12'd400, rgb(16'd300, 16'd5000, 16'd40));
  endtask

  task automatic test_random_traffic();
    logic [CFG_DATA_BITS-1:0] vres;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       vres = 13'd480;
        1:       vres = 13'd1;
        2:       vres = 13'd4096;
        3:       vres = 13'h1FFF;
        4:       vres = 13'd0;
        5:       vres = 13'd1080;
        default: vres = CFG_DATA_BITS'($urandom_range(1, 8191));
      endcase
      set_mode(p[0], p[1], vres);
      case (p % 4)
        0: begin tx_gap_lim = 0;       rx_gap_lim = 0;       end
        1: begin tx_gap_lim = MAX_GAP; rx_gap_lim = MAX_GAP; end
        2: begin tx_gap_lim = 0;       rx_gap_lim = MAX_GAP; end
        default: begin tx_gap_lim = MAX_GAP; rx_gap_lim = 0; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p[0] && i == PHASE_ITEMS / 2) wait_idle();
        if ($urandom_range(0, 9) < 2)
          load_lut(GAMMA_INDEX_BITS'($urandom), PIX_BITS'($urandom));
        else
          send_pixel(COORD_BITS'($urandom), COORD_BITS'($urandom),
                     rgb(pick_radiance(), pick_radiance(), pick_radiance()));
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // output side: stall drawn per transaction
  always @(negedge clk) begin
    if (rx_took) begin
      rx_wait = $urandom_range(0, rx_gap_lim);
      rx_took = 1'b0;
    end
    if (rx_wait > 0) begin
      out_tready <= 1'b0;
      rx_wait--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      rx_took = 1'b1;
      if (pixel_due_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual %h", $time, out_tdata);
      end else begin
        due_pix = pixel_due_q.pop_front();
        check_field("x_out", due_pix.x, out_tdata[OUT_X_LSB +: COORD_BITS]);
        check_field("y_out", due_pix.y, out_tdata[OUT_Y_LSB +: COORD_BITS]);
        check_field("red_out", due_pix.red, out_tdata[OUT_RED_LSB +: PIX_BITS]);
        check_field("green_out", due_pix.green, out_tdata[OUT_GREEN_LSB +: PIX_BITS]);
        check_field("blue_out", due_pix.blue, out_tdata[OUT_BLUE_LSB +: PIX_BITS]);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = REQ_PIXEL;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_addr   = '0;
    cfg_data   = '0;
    clamp_on   = 1'b0;
    gamma_on   = 1'b0;
    vres_q     = VRES_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_reset_defaults();
    test_clamp_linear();
    test_gamma_lookup();
    test_flip_extremes();
    test_random_traffic();
    wait_idle();
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
